/* rtl/mmcpu_pkg.sv */
`default_nettype none

package mmcpu_pkg;

  // default tape depth (words); must be a power of two
  localparam int TAPE_WORDS_DEFAULT = 512;

  // input actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_EXEC  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_CHAR = 3'd1;
  localparam logic [2:0] KIND_NUM  = 3'd2;
  localparam logic [2:0] KIND_READ = 3'd3;
  localparam logic [2:0] KIND_HALT = 3'd4;

  // opcodes, as held in the opcode register
  typedef enum logic [3:0] {
    OP_HALT = 4'd0,
    OP_ADD  = 4'd1,
    OP_MUL  = 4'd2,
    OP_CLT  = 4'd3,
    OP_CEQ  = 4'd4,
    OP_JMP  = 4'd5,
    OP_JNZ  = 4'd6,
    OP_CPY  = 4'd7,
    OP_PUTC = 4'd8,
    OP_PUTN = 4'd9
  } opcode_t;

  // highest defined opcode, for the unknown-opcode check on a full word
  localparam logic [31:0] OP_LAST = 32'd9;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_DEC,
    S_PTR1,
    S_OPA,
    S_PTR2,
    S_OPB,
    S_DST
  } state_t;

endpackage

`default_nettype wire

/* rtl/memory_to_memory_cpu_step.sv */
`default_nettype none

// Tiny memory-to-memory processor with one single-port tape memory of
// TAPE_WORDS 32-bit words (a power of two). A transaction is taken when
// start is high and busy is low; its single result appears on kind,
// value_res, halted and program_counter, marked by done for exactly one
// cycle, and must be taken in that cycle since the block cannot be stalled.
// A write and an execute while halted end in S_IDLE, a read passes through
// S_RDATA, and an executed instruction steps through S_DEC, S_PTR1 and
// S_OPA, then S_PTR2 and S_OPB for add, multiply, compare and a taken
// jump-if-nonzero, and S_DST for add, multiply, compare and copy; halt and
// an unknown opcode end in S_DEC. Each is followed by the done cycle, in
// which the next start is accepted. The sequence is set by the one memory
// port: every opcode, pointer and operand fetch is its own registered read.
module memory_to_memory_cpu_step
  import mmcpu_pkg::*;
#(
  parameter int TAPE_WORDS = TAPE_WORDS_DEFAULT,
  localparam int AW = $clog2(TAPE_WORDS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [1:0]          action,
  input  wire logic [AW-1:0]       address,
  input  wire logic signed [31:0]  value,
  output      logic                done,
  output      logic [2:0]          kind,
  output      logic signed [31:0]  value_res,
  output      logic                halted,
  output      logic [AW-1:0]       program_counter
);

  state_t state, state_next;

  logic [31:0]   tape [TAPE_WORDS];
  logic [31:0]   rdata;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [31:0]   mem_wdata;

  opcode_t       op;
  logic [31:0]   a_val, b_val;
  logic [AW-1:0] pc;

  logic          finish;
  logic          op_load, a_load, b_load;
  logic [2:0]    kind_next;
  logic [31:0]   res_next;
  logic [AW-1:0] pc_next;
  logic          halt_next;
  logic [31:0]   alu_out;
  logic [31:0]   prod;
  logic          op_unknown;
  logic          op_is_halt;
  logic [AW-1:0] rd_ptr;

  assign busy            = (state != S_IDLE);
  assign program_counter = pc;
  assign rd_ptr          = rdata[AW-1:0];
  assign op_unknown      = (rdata > OP_LAST);
  assign op_is_halt      = (rdata == 32'(OP_HALT));

  // tape memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tape[mem_addr] <= mem_wdata;
    end
    rdata <= tape[mem_addr];
  end

  // shared arithmetic / compare unit
  assign prod = a_val * b_val;
  always_comb begin
    case (op)
      OP_ADD:  alu_out = a_val + b_val;
      OP_MUL:  alu_out = prod;
      OP_CLT:  alu_out = {31'd0, ($signed(a_val) < $signed(b_val))};
      OP_CEQ:  alu_out = {31'd0, (a_val == b_val)};
      default: alu_out = a_val;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && (action == ACT_READ)) begin
          state_next = S_RDATA;
        end else if (start && (action == ACT_EXEC) && !halted) begin
          state_next = S_DEC;
        end
      end
      S_RDATA: state_next = S_IDLE;
      S_DEC: begin
        if (op_is_halt || op_unknown) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_PTR1;
        end
      end
      S_PTR1: state_next = S_OPA;
      S_OPA: begin
        case (op)
          OP_CPY:  state_next = S_DST;
          OP_JNZ:  state_next = (rdata == 32'd0) ? S_IDLE : S_PTR2;
          OP_ADD, OP_MUL, OP_CLT, OP_CEQ: state_next = S_PTR2;
          default: state_next = S_IDLE;
        endcase
      end
      S_PTR2: state_next = S_OPB;
      S_OPB:  state_next = (op == OP_JNZ) ? S_IDLE : S_DST;
      S_DST:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: memory port, loads, and result of a finished item
  always_comb begin
    mem_addr  = pc;
    mem_we    = 1'b0;
    mem_wdata = value;
    finish    = 1'b0;
    op_load   = 1'b0;
    a_load    = 1'b0;
    b_load    = 1'b0;
    kind_next = KIND_NONE;
    res_next  = 32'd0;
    pc_next   = pc;
    halt_next = halted;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_WRITE: begin
              mem_addr = address;
              mem_we   = 1'b1;
              finish   = 1'b1;
            end
            ACT_READ: mem_addr = address;
            ACT_EXEC: begin
              mem_addr = pc;
              if (halted) begin
                finish    = 1'b1;
                kind_next = KIND_HALT;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_RDATA: begin
        finish    = 1'b1;
        kind_next = KIND_READ;
        res_next  = rdata;
      end
      S_DEC: begin
        if (op_is_halt) begin
          finish    = 1'b1;
          halt_next = 1'b1;
          kind_next = KIND_HALT;
        end else if (op_unknown) begin
          finish = 1'b1;
        end else begin
          op_load  = 1'b1;
          mem_addr = pc + AW'(1);
        end
      end
      S_PTR1: mem_addr = rd_ptr;
      S_OPA: begin
        a_load = 1'b1;
        case (op)
          OP_JMP: begin
            finish  = 1'b1;
            pc_next = rd_ptr;
          end
          OP_PUTC: begin
            finish    = 1'b1;
            kind_next = KIND_CHAR;
            res_next  = {24'd0, rdata[7:0]};
            pc_next   = pc + AW'(2);
          end
          OP_PUTN: begin
            finish    = 1'b1;
            kind_next = KIND_NUM;
            res_next  = rdata;
            pc_next   = pc + AW'(2);
          end
          OP_JNZ: begin
            if (rdata == 32'd0) begin
              finish  = 1'b1;
              pc_next = pc + AW'(3);
            end else begin
              mem_addr = pc + AW'(2);
            end
          end
          default: mem_addr = pc + AW'(2);
        endcase
      end
      S_PTR2: mem_addr = rd_ptr;
      S_OPB: begin
        b_load = 1'b1;
        if (op == OP_JNZ) begin
          finish  = 1'b1;
          pc_next = rd_ptr;
        end else begin
          mem_addr = pc + AW'(3);
        end
      end
      S_DST: begin
        mem_addr  = rd_ptr;
        mem_we    = 1'b1;
        mem_wdata = alu_out;
        finish    = 1'b1;
        pc_next   = (op == OP_CPY) ? (pc + AW'(3)) : (pc + AW'(4));
      end
      default: finish = 1'b1;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= '0;
      halted <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      halted <= halt_next;
      done   <= finish;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (op_load) begin
      op <= opcode_t'(rdata[3:0]);
    end
    if (a_load) begin
      a_val <= rdata;
    end
    if (b_load) begin
      b_val <= rdata;
    end
    if (finish) begin
      kind      <= kind_next;
      value_res <= res_next;
    end
  end

endmodule

`default_nettype wire
